// File: hw/rtl/mft_pkg.sv
// Shared types, constants and functions of the Manchester frame transmitter.
`default_nettype none

package mft_pkg;

   // Number of payload bytes in one frame. The check byte follows them.
   localparam int PAYLOAD_BYTES = 3;
   localparam int FRAME_LEN     = PAYLOAD_BYTES + 1;
   localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
   localparam int IDX_W         = $clog2(FRAME_LEN);
   localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);

   localparam logic [7:0] CRC_POLY_RESET = 8'h8C;
   localparam logic [7:0] MASK_FIRST     = 8'h80;

   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic line_out;
      logic busy_res;
   } rsp_type;

   // One byte of a reflected CRC-8, processed LSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = {1'b0, c[7:1]} ^ poly;
         end else begin
            c = {1'b0, c[7:1]};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/manchester_frame_transmitter.sv
// Top level of the Manchester frame transmitter: beat registers, CSR and units.
//
//   Channel   Direction  Handshake              Beat contents
//   req_      in         req_valid / req_ready  req_data: action, payload
//   rsp_      out        rsp_valid / rsp_ready  rsp_data: line_out, busy_res
//   csr_      in         csr_wr_en (no wait)    csr_wr_data: CRC polynomial
//
// Every request beat produces exactly one response beat. An accepted beat is
// held in the input register, processed by the encoder and lands in the
// response register, so one beat per cycle flows when rsp_ready stays high.
// The response beat is presented from the response register after its request
// beat has passed through the input register. A byte-serial unit computes the
// check byte after a start beat, long before the sequencer reaches that byte.
// Reset is synchronous and active high and returns the line low and idle.
// A stall on the response side holds both registers; req_ready drops only
// when the input register is full and cannot move forward.
`default_nettype none

module manchester_frame_transmitter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mft_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mft_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data
);
   import mft_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic [7:0] poly_ff;

   logic       advance;
   rsp_type    enc_result;
   logic       crc_start;
   logic       crc_busy;
   logic [7:0] crc_value;
   logic       sending;

   // The held beat moves into the response register whenever that register
   // is empty or is being drained in this same cycle.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         poly_ff      <= CRC_POLY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            poly_ff <= csr_wr_data;
         end
      end
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= enc_result;
      end
   end

   mft_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_ff),
      .crc       (crc_value),
      .crc_start (crc_start),
      .sending   (sending),
      .result    (enc_result)
   );

   mft_crc u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_start),
      .data  (in_ff.payload),
      .poly  (poly_ff),
      .crc   (crc_value),
      .busy  (crc_busy)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // The check byte must be settled before any data bit is sent.
   a_crc_ready: assert property (@(posedge clock) disable iff (reset)
      sending |-> !crc_busy)
      else $error("frame bits sent while the check byte is still computing");

   a_start_steps: assert property (@(posedge clock) disable iff (reset)
      crc_start |-> advance && in_ff.action == ACTION_START)
      else $error("check byte started without a start beat moving forward");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("held request beat lost or altered");

endmodule

`default_nettype wire

// File: hw/rtl/mft_crc.sv
// Byte-serial CRC-8 unit that folds the latched payload one byte per cycle.
`default_nettype none

module mft_crc (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mft_pkg::PAYLOAD_W-1:0] data,
   input  wire logic [7:0]                    poly,
   output logic      [7:0]                    crc,
   output logic                               busy
);
   import mft_pkg::*;

   logic [CNT_W-1:0]     left_ff,  left_in;
   logic [PAYLOAD_W-1:0] shift_ff, shift_in;
   logic [7:0]           crc_ff,   crc_in;

   always_comb begin
      left_in  = left_ff;
      shift_in = shift_ff;
      crc_in   = crc_ff;
      if (start) begin
         left_in  = CNT_W'(PAYLOAD_BYTES);
         shift_in = data;
         crc_in   = 8'h00;
      end else if (left_ff != '0) begin
         crc_in   = crc8_byte(crc_ff, shift_ff[PAYLOAD_W-1 -: 8], poly);
         shift_in = shift_ff << 8;
         left_in  = left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      shift_ff <= shift_in;
      crc_ff   <= crc_in;
   end

   assign crc  = crc_ff;
   assign busy = (left_ff != '0);

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= CNT_W'(PAYLOAD_BYTES))
      else $error("crc byte counter out of range");

endmodule

`default_nettype wire

// File: hw/rtl/mft_encoder.sv
// Frame sequencer and Manchester half-bit encoder state.
`default_nettype none

module mft_encoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire mft_pkg::req_type item,
   input  wire logic [7:0]       crc,
   output logic                  crc_start,
   output logic                  sending,
   output mft_pkg::rsp_type      result
);
   import mft_pkg::*;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_INIT = 3'd1;
   localparam logic [2:0] MODE_SYNC = 3'd2;
   localparam logic [2:0] MODE_SEND = 3'd3;
   localparam logic [2:0] MODE_END  = 3'd4;

   localparam logic [1:0] HALF_NONE   = 2'd0;
   localparam logic [1:0] HALF_SECOND = 2'd1;
   localparam logic [1:0] HALF_FIRST  = 2'd2;

   logic                 line_ff,    line_in;
   logic [1:0]           half_ff,    half_in;
   logic                 cur_ff,     cur_in;
   logic [2:0]           mode_ff,    mode_in;
   logic [7:0]           mask_ff,    mask_in;
   logic [IDX_W-1:0]     idx_ff,     idx_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;

   logic       busy;
   logic [7:0] cur_byte;
   logic [7:0] mask_shift;

   assign busy       = (mode_ff != MODE_IDLE) || (half_ff != HALF_NONE);
   assign mask_shift = {1'b0, mask_ff[7:1]};

   // Payload bytes go out first-latched-high-byte first; the check byte is last.
   always_comb begin
      cur_byte = crc;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         if (idx_ff == IDX_W'(i)) begin
            cur_byte = payload_ff[8*(PAYLOAD_BYTES-1-i) +: 8];
         end
      end
   end

   always_comb begin
      line_in    = line_ff;
      half_in    = half_ff;
      cur_in     = cur_ff;
      mode_in    = mode_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      payload_in = payload_ff;
      crc_start  = 1'b0;
      if (item.action == ACTION_START) begin
         if (!busy) begin
            payload_in = item.payload;
            idx_in     = '0;
            mode_in    = MODE_INIT;
            crc_start  = step;
         end
      end else if (half_ff == HALF_FIRST) begin
         line_in = ~cur_ff;
         half_in = HALF_SECOND;
      end else begin
         if (half_ff == HALF_SECOND) begin
            line_in = cur_ff;
         end
         half_in = HALF_NONE;
         case (mode_ff)
            MODE_IDLE: begin
               mode_in = MODE_IDLE;
            end
            MODE_INIT: begin
               mask_in = MASK_FIRST;
               mode_in = MODE_SYNC;
            end
            MODE_SYNC: begin
               cur_in  = 1'b1;
               half_in = HALF_FIRST;
               mask_in = mask_shift;
               if (mask_shift == 8'h00) begin
                  cur_in  = 1'b0;
                  idx_in  = '0;
                  mask_in = MASK_FIRST;
                  mode_in = MODE_SEND;
               end
            end
            MODE_SEND: begin
               cur_in  = |(cur_byte & mask_ff);
               half_in = HALF_FIRST;
               mask_in = mask_shift;
               if (mask_shift == 8'h00) begin
                  mask_in = MASK_FIRST;
                  if (idx_ff == IDX_W'(FRAME_LEN - 1)) begin
                     mode_in = MODE_END;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
            MODE_END: begin
               cur_in  = 1'b0;
               half_in = HALF_FIRST;
               mode_in = MODE_IDLE;
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= 1'b0;
         half_ff <= HALF_NONE;
         cur_ff  <= 1'b0;
         mode_ff <= MODE_IDLE;
         mask_ff <= 8'h00;
         idx_ff  <= '0;
      end else if (step) begin
         line_ff <= line_in;
         half_ff <= half_in;
         cur_ff  <= cur_in;
         mode_ff <= mode_in;
         mask_ff <= mask_in;
         idx_ff  <= idx_in;
      end
      if (step) begin
         payload_ff <= payload_in;
      end
   end

   assign result.line_out = line_in;
   assign result.busy_res = (mode_in != MODE_IDLE) || (half_in != HALF_NONE);
   assign sending         = (mode_ff == MODE_SEND);

   a_half_code: assert property (@(posedge clock) disable iff (reset)
      half_ff != 2'd3)
      else $error("half-bit phase holds an unused code");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_INIT |-> half_ff == HALF_NONE)
      else $error("set-up step entered with a half-bit pending");

   a_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(mask_ff))
      else $error("bit mask has more than one bit set");

endmodule

`default_nettype wire

// File: tb/sv/tb_manchester_frame_transmitter.sv
// Self-checking testbench for the Manchester frame transmitter.
`timescale 1ns / 100ps

module tb_manchester_frame_transmitter;

   // Frame sequencer modes of the line predictor.
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_INIT,
      MODE_SYNC,
      MODE_SEND,
      MODE_END
   } line_mode_type;

   // Half-bit bookkeeping: which half of the current bit is still to be driven.
   localparam logic [1:0] HALF_NONE   = 2'd0;
   localparam logic [1:0] HALF_SECOND = 2'd1;
   localparam logic [1:0] HALF_FIRST  = 2'd2;

   // A directed row is either one beat or a run of ticks until the frame ends.
   typedef enum logic {
      ROW_BEAT,
      ROW_DRAIN
   } row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic                          action;
      logic [mft_pkg::PAYLOAD_W-1:0] payload;
      logic                          typed;
      logic                          exp_line;
      logic                          exp_busy;
   } stim_row_type;

   localparam int IDX_W        = mft_pkg::IDX_W;
   localparam int NUM_ROWS     = 18;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 40;
   localparam int SETTLE_PAD   = 8;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PRINT_LIMIT  = 20;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   mft_pkg::req_type      req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   mft_pkg::rsp_type      rsp_data;
   logic                  csr_wr_en;
   logic [7:0]            csr_wr_data;

   // Line predictor state, a private copy of what the transmitter holds.
   logic [7:0]            poly_m;
   logic                  level_m;
   logic [1:0]            half_m;
   logic                  bit_m;
   line_mode_type         mode_m;
   logic [7:0]            mask_m;
   logic [IDX_W-1:0]      byte_idx_m;
   logic [7:0]            frame_bytes_m [mft_pkg::FRAME_LEN];

   // Predicted line levels, oldest first, waiting for their response beats.
   mft_pkg::rsp_type      pending_levels [$];

   int                    mismatch_count = 0;
   int                    rsp_seen = 0;
   int                    cycle_count = 0;
   bit                    sender_steady = 1'b0;
   bit                    receiver_steady = 1'b0;
   bit                    long_hold_req = 1'b0;

   // Directed rows. Expected levels are typed in where they are obvious: the
   // idle line after reset, the silent set-up steps, the first 1 of the sync
   // run and ignored starts. All other rows go through the predictor.
   stim_row_type directed_rows [NUM_ROWS] = '{
      // A tick while idle changes nothing.
      '{ROW_BEAT,  mft_pkg::ACTION_TICK,  24'h000000, 1'b1, 1'b0, 1'b0},
      // All-ones payload; the line stays low until the first half-bit.
      '{ROW_BEAT,  mft_pkg::ACTION_START, 24'hFFFFFF, 1'b1, 1'b0, 1'b1},
      // A start right behind another one is ignored.
      '{ROW_BEAT,  mft_pkg::ACTION_START, 24'h000000, 1'b1, 1'b0, 1'b1},
      // Set-up step, then the silent load of the first sync bit.
      '{ROW_BEAT,  mft_pkg::ACTION_TICK,  24'h000000, 1'b1, 1'b0, 1'b1},
      '{ROW_BEAT,  mft_pkg::ACTION_TICK,  24'h000000, 1'b1, 1'b0, 1'b1},
      // First sync bit is a 1: low half, then high half.
      '{ROW_BEAT,  mft_pkg::ACTION_TICK,  24'h000000, 1'b1, 1'b0, 1'b1},
      '{ROW_BEAT,  mft_pkg::ACTION_TICK,  24'h000000, 1'b1, 1'b1, 1'b1},
      // A start in the middle of a frame is ignored and the line holds.
      '{ROW_BEAT,  mft_pkg::ACTION_START, 24'h123456, 1'b1, 1'b1, 1'b1},
      '{ROW_DRAIN, mft_pkg::ACTION_TICK,  24'h000000, 1'b0, 1'b0, 1'b0},
      // Start on the tick right after the last half-bit is taken; the closing
      // 0 bit ends high then low, so the line is low.
      '{ROW_BEAT,  mft_pkg::ACTION_START, 24'h000000, 1'b1, 1'b0, 1'b1},
      '{ROW_DRAIN, mft_pkg::ACTION_TICK,  24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_BEAT,  mft_pkg::ACTION_TICK,  24'h000000, 1'b1, 1'b0, 1'b0},
      '{ROW_BEAT,  mft_pkg::ACTION_START, 24'h800001, 1'b0, 1'b0, 1'b0},
      '{ROW_DRAIN, mft_pkg::ACTION_TICK,  24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_BEAT,  mft_pkg::ACTION_START, 24'h7FFFFE, 1'b0, 1'b0, 1'b0},
      '{ROW_DRAIN, mft_pkg::ACTION_TICK,  24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_BEAT,  mft_pkg::ACTION_START, 24'hA55AC3, 1'b0, 1'b0, 1'b0},
      '{ROW_DRAIN, mft_pkg::ACTION_TICK,  24'h000000, 1'b0, 1'b0, 1'b0}
   };

   manchester_frame_transmitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A frame is in progress while the sequencer runs or a half-bit is pending.
   function automatic logic frame_busy();
      return (mode_m != MODE_IDLE) || (half_m != HALF_NONE);
   endfunction

   // Reflected CRC-8 over the payload, fed one bit at a time, LSB of each
   // byte first, starting from zero.
   function automatic logic [7:0] payload_crc(input logic [mft_pkg::PAYLOAD_W-1:0] pay,
                                              input logic [7:0] poly);
      logic [7:0] crc;
      logic [7:0] data;
      logic       fb;
      crc = 8'h00;
      for (int b = 0; b < mft_pkg::PAYLOAD_BYTES; b++) begin
         data = pay[mft_pkg::PAYLOAD_W - 1 - 8 * b -: 8];
         for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ data[k];
            crc = crc >> 1;
            if (fb) begin
               crc = crc ^ poly;
            end
         end
      end
      return crc;
   endfunction

   // Applies one beat to the predictor and returns the line it should show.
   function automatic mft_pkg::rsp_type advance_line(input mft_pkg::req_type beat);
      mft_pkg::rsp_type r;
      logic [7:0]       cur_byte;
      if (beat.action == mft_pkg::ACTION_START) begin
         // Starts are only taken while idle; otherwise nothing moves.
         if (!frame_busy()) begin
            for (int i = 0; i < mft_pkg::PAYLOAD_BYTES; i++) begin
               frame_bytes_m[i] = beat.payload[mft_pkg::PAYLOAD_W - 1 - 8 * i -: 8];
            end
            frame_bytes_m[mft_pkg::PAYLOAD_BYTES] = payload_crc(beat.payload, poly_m);
            byte_idx_m = '0;
            mode_m     = MODE_INIT;
         end
      end else if (half_m == HALF_FIRST) begin
         // First half of a bit is the inverted bit value.
         level_m = ~bit_m;
         half_m  = HALF_SECOND;
      end else begin
         // Second half (if pending) and the load of the next bit share a tick.
         if (half_m == HALF_SECOND) begin
            level_m = bit_m;
         end
         half_m = HALF_NONE;
         case (mode_m)
            MODE_INIT: begin
               mask_m = mft_pkg::MASK_FIRST;
               mode_m = MODE_SYNC;
            end
            MODE_SYNC: begin
               bit_m  = 1'b1;
               half_m = HALF_FIRST;
               mask_m = mask_m >> 1;
               if (mask_m == 8'h00) begin
                  // Seven ones are out; this one is the 0 start bit.
                  bit_m      = 1'b0;
                  byte_idx_m = '0;
                  mask_m     = mft_pkg::MASK_FIRST;
                  mode_m     = MODE_SEND;
               end
            end
            MODE_SEND: begin
               cur_byte = frame_bytes_m[byte_idx_m];
               bit_m    = |(cur_byte & mask_m);
               half_m   = HALF_FIRST;
               mask_m   = mask_m >> 1;
               if (mask_m == 8'h00) begin
                  mask_m = mft_pkg::MASK_FIRST;
                  if (byte_idx_m + 1 >= mft_pkg::FRAME_LEN) begin
                     mode_m = MODE_END;
                  end else begin
                     byte_idx_m = byte_idx_m + IDX_W'(1);
                  end
               end
            end
            MODE_END: begin
               bit_m  = 1'b0;
               half_m = HALF_FIRST;
               mode_m = MODE_IDLE;
            end
            default: begin
               mode_m = MODE_IDLE;
            end
         endcase
      end
      r.line_out = level_m;
      r.busy_res = frame_busy();
      return r;
   endfunction

   // Stall lengths: mostly short, now and then a long one.
   function automatic int pick_pause();
      if ($urandom_range(0, 99) < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 40);
   endfunction

   function automatic logic [mft_pkg::PAYLOAD_W-1:0] pick_payload();
      int          sel;
      logic [31:0] raw;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return '0;
      end else if (sel == 1) begin
         return '1;
      end
      raw = $urandom();
      return raw[mft_pkg::PAYLOAD_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic got, input logic want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] response beat %0d: %s is %b, predicted %b",
                  $realtime, rsp_seen, what, got, want);
      end
   endtask

   // Offers one beat and holds it until it is taken, then books the predicted
   // line and maybe leaves a gap. Called at a rising edge.
   task automatic send_beat(input mft_pkg::req_type beat, input bit use_typed,
                            input mft_pkg::rsp_type typed_rsp);
      mft_pkg::rsp_type predicted;
      int               gap;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = advance_line(beat);
      pending_levels.push_back(use_typed ? typed_rsp : predicted);
      gap = 0;
      if (!sender_steady && $urandom_range(0, 99) < 35) begin
         gap = pick_pause();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Ticks until the frame on the line has fully ended.
   task automatic finish_frame();
      mft_pkg::req_type tick;
      tick.action  = mft_pkg::ACTION_TICK;
      tick.payload = '0;
      while (frame_busy()) begin
         send_beat(tick, 1'b0, '0);
      end
   endtask

   // Stops offering and waits until every booked beat has come back, then idles
   // for a settling pad so that anything still inside the pipeline drains.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   task automatic write_poly(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      poly_m = value;
   endtask

   // Receiver: ready most of the time, short and long stalls at random, and
   // one long hold-off on request so the input side has to back up.
   initial begin
      int   stall_left;
      logic next_ready;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end
         if (stall_left > 0) begin
            next_ready = 1'b0;
            stall_left--;
         end else begin
            next_ready = 1'b1;
            if (!receiver_steady && $urandom_range(0, 99) < 30) begin
               stall_left = pick_pause();
            end
         end
         rsp_ready <= next_ready;
      end
   end

   // Every response beat is matched against the oldest booked prediction.
   always @(posedge clock) begin
      mft_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_levels.size() == 0) begin
            report_mismatch("unexpected beat, line_out", rsp_data.line_out, 1'bx);
         end else begin
            want = pending_levels.pop_front();
            if (rsp_data.line_out !== want.line_out) begin
               report_mismatch("line_out", rsp_data.line_out, want.line_out);
            end
            if (rsp_data.busy_res !== want.busy_res) begin
               report_mismatch("busy_res", rsp_data.busy_res, want.busy_res);
            end
         end
         rsp_seen++;
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      mft_pkg::req_type beat;
      mft_pkg::rsp_type typed_rsp;
      logic [7:0]       poly;
      logic [7:0]       phase_polys [NUM_PHASES];
      int               counted;
      bit               ignored;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'h00;

      // Predictor starts from the post-reset state.
      poly_m     = mft_pkg::CRC_POLY_RESET;
      level_m    = 1'b0;
      half_m     = HALF_NONE;
      bit_m      = 1'b0;
      mode_m     = MODE_IDLE;
      mask_m     = 8'h00;
      byte_idx_m = '0;
      for (int i = 0; i < mft_pkg::FRAME_LEN; i++) begin
         frame_bytes_m[i] = 8'h00;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the reset polynomial.
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_DRAIN) begin
            finish_frame();
         end else begin
            beat.action        = directed_rows[r].action;
            beat.payload       = directed_rows[r].payload;
            typed_rsp.line_out = directed_rows[r].exp_line;
            typed_rsp.busy_res = directed_rows[r].exp_busy;
            send_beat(beat, directed_rows[r].typed, typed_rsp);
         end
      end
      quiesce();

      // Random phases, each with its own polynomial. The zero and all-ones
      // polynomials and the single-bit extremes are among them.
      phase_polys = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h8C, 8'h00, 8'h07};
      phase_polys[4] = 8'($urandom_range(0, 255));
      phase_polys[6] = 8'($urandom_range(0, 255));

      for (int p = 0; p < NUM_PHASES; p++) begin
         poly = phase_polys[p];
         write_poly(poly);

         // Phase 1 holds the receiver off for a long stretch while the sender
         // keeps offering; phase 2 runs flat out on both sides.
         sender_steady   = (p == 1) || (p == 2);
         receiver_steady = (p == 2);
         if (p == 1) begin
            long_hold_req = 1'b1;
         end

         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // Mostly whole frames: start as soon as the line is idle, and
            // only rarely throw a start at a busy frame.
            if (!frame_busy()) begin
               beat.action = ($urandom_range(0, 99) < 85) ? mft_pkg::ACTION_START
                                                          : mft_pkg::ACTION_TICK;
            end else begin
               beat.action = ($urandom_range(0, 99) < 4) ? mft_pkg::ACTION_START
                                                         : mft_pkg::ACTION_TICK;
            end
            beat.payload = pick_payload();
            ignored = (beat.action == mft_pkg::ACTION_START) && frame_busy();
            send_beat(beat, 1'b0, '0);
            if (!ignored) begin
               counted++;
            end
            // Once, pause mid-frame until every response is back.
            if (p == 3 && counted == 20 && !ignored) begin
               quiesce();
            end
         end

         finish_frame();
         quiesce();
      end

      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      quiesce();

      if (mismatch_count == 0 && pending_levels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
